/* rtl/csma_transmit_controller_assert.svh */
// Assertion macros used by the send state machine of the transmit controller RTL.
// Needs nothing but a clock, a reset and the signals named in each use.
`ifndef CSMA_TRANSMIT_CONTROLLER_ASSERT_SVH
`define CSMA_TRANSMIT_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define CSMA_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("csma assertion failed");

// Next-cycle implication.
`define CSMA_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("csma assertion failed");

`endif

/* rtl/csma_pkg.sv */
// Shared types and constants of the CSMA transmit controller.
// No dependencies; the other RTL modules import it, and csma_if uses its types.
`default_nettype none

package csma_pkg;

  localparam int unsigned MAX_PAYLOAD = 255;
  localparam logic [7:0]  FAILURE_CODE = 8'd1;
  localparam logic [1:0]  LIFE_MAX = 2'd3;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ASSESS = 2'd1,
    PH_TX     = 2'd2,
    PH_HOLD   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SUB_TX   = 2'd0,
    SUB_CCA  = 2'd1,
    SUB_WAIT = 2'd2
  } sub_phase_t;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_CONFIRM = 3'd1,
    ACT_DATA    = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_POLL    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_CCA  = 2'd1,
    CMD_TX   = 2'd2
  } command_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_BACKOFF_SLOTS = 4'd0,
    CFG_START_TIMEOUT     = 4'd1,
    CFG_ACK_TIMEOUT       = 4'd2,
    CFG_HOLD_TIMEOUT      = 4'd3,
    CFG_MAX_ATTEMPTS      = 4'd4,
    CFG_OWN_NET_ID        = 4'd5,
    CFG_BROADCAST_NET_ID  = 4'd6,
    CFG_HOLD_RESULT       = 4'd7
  } cfg_index_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        channel_busy;
    logic [7:0]  backoff_draw;
    logic        phy_tx_done;
    logic [7:0]  phy_tx_code;
    logic [7:0]  frame_handle;
    logic [15:0] payload_length;
    logic [7:0]  life_period;
    logic        network_wide;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        tx_is_stop_relay;
    logic [7:0]  tx_handle;
    logic [7:0]  tx_length;
    logic [15:0] tx_net_id;
    logic [1:0]  tx_life;
    logic [1:0]  send_phase;
    logic [7:0]  last_result;
    logic        request_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  max_backoff_slots;
    logic [15:0] start_timeout;
    logic [15:0] ack_timeout;
    logic [15:0] hold_timeout;
    logic [7:0]  max_attempts;
    logic [15:0] own_net_id;
    logic [15:0] broadcast_net_id;
    logic        hold_result;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_backoff_slots: 8'd8,
    start_timeout:     16'd1000,
    ack_timeout:       16'd1000,
    hold_timeout:      16'd1000,
    max_attempts:      8'd4,
    own_net_id:        16'd0,
    broadcast_net_id:  16'hFFFF,
    hold_result:       1'b0
  };

endpackage

`default_nettype wire

/* rtl/csma_if.sv */
// Channel interfaces of the CSMA transmit controller: request, response, config.
// Depends on csma_pkg for the payload types and config widths.
`default_nettype none

interface csma_req_if;
  logic                valid;
  logic                ready;
  csma_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csma_rsp_if;
  logic                valid;
  logic                ready;
  csma_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csma_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [csma_pkg::CFG_INDEX_W-1:0]  index;
  logic [csma_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/csma_cfg.sv */
// Configuration register file of the CSMA transmit controller.
// Depends on csma_pkg; written through a valid/ready write channel.
`default_nettype none

module csma_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_valid,
  output logic                              wr_ready,
  input  logic [csma_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0]   wr_data,
  output csma_pkg::cfg_t                    cfg
);
  import csma_pkg::*;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_valid) begin
      unique case (wr_index)
        CFG_MAX_BACKOFF_SLOTS: cfg.max_backoff_slots <= wr_data[7:0];
        CFG_START_TIMEOUT:     cfg.start_timeout <= wr_data;
        CFG_ACK_TIMEOUT:       cfg.ack_timeout <= wr_data;
        CFG_HOLD_TIMEOUT:      cfg.hold_timeout <= wr_data;
        CFG_MAX_ATTEMPTS:      cfg.max_attempts <= wr_data[7:0];
        CFG_OWN_NET_ID:        cfg.own_net_id <= wr_data;
        CFG_BROADCAST_NET_ID:  cfg.broadcast_net_id <= wr_data;
        CFG_HOLD_RESULT:       cfg.hold_result <= wr_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/csma_in_stage.sv */
// Input register of the CSMA transmit controller: holds one request word.
// Depends on csma_pkg for the request type.
`default_nettype none

module csma_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  csma_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output csma_pkg::in_item_t out_data
);
  import csma_pkg::*;

  logic valid;

  // take a new word when empty or whenever the held one leaves this cycle
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= in_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/csma_out_stage.sv */
// Result register of the CSMA transmit controller: holds one result word.
// Depends on csma_pkg for the result type.
`default_nettype none

module csma_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  csma_pkg::out_item_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csma_pkg::out_item_t out_data
);
  import csma_pkg::*;

  logic valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= in_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/csma_core.sv */
// Send state machine of the CSMA transmit controller: one word per update.
// Depends on csma_pkg and csma_transmit_controller_assert.svh.
`default_nettype none

module csma_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  csma_pkg::in_item_t  item,
  input  csma_pkg::cfg_t      cfg,
  output csma_pkg::out_item_t result
);
  import csma_pkg::*;

  typedef struct packed {
    phase_t      phase;
    sub_phase_t  sub_phase;
    logic [15:0] start_count;
    logic [15:0] ack_count;
    logic [15:0] hold_count;
    logic [7:0]  backoff_left;
    logic [7:0]  attempts;
    logic [7:0]  result_code;
    logic        pending_stop;
    logic        pending_data;
    logic [7:0]  stop_handle;
    logic [7:0]  data_handle;
    logic [7:0]  data_length;
    logic [1:0]  stop_life;
    logic [15:0] stop_net;
  } state_t;

  state_t st;
  state_t st_next;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  always_comb begin : next_state
    state_t     n;
    logic [7:0] top;
    logic [7:0] draw;
    logic       go_stop;
    logic       go_data;
    logic       go_tx;

    n = st;
    top = '0;
    draw = '0;
    go_stop = 1'b0;
    go_data = 1'b0;
    go_tx = 1'b0;

    unique case (item.action)
      ACT_TICK: begin
        if (n.phase == PH_ASSESS) begin
          n.start_count = inc16(n.start_count);
          if (n.start_count >= cfg.start_timeout) begin
            n.result_code = FAILURE_CODE;
            n.hold_count = '0;
            n.phase = cfg.hold_result ? PH_HOLD : PH_IDLE;
          end else if (n.sub_phase == SUB_WAIT) begin
            if (n.backoff_left != 8'd0) begin
              n.backoff_left = n.backoff_left - 8'd1;
            end
            if (n.backoff_left == 8'd0) begin
              n.sub_phase = SUB_CCA;
            end
          end
        end
        if (n.phase == PH_TX) begin
          n.ack_count = inc16(n.ack_count);
          if (n.ack_count >= cfg.ack_timeout || item.phy_tx_done) begin
            n.result_code = (n.ack_count >= cfg.ack_timeout) ? FAILURE_CODE
                                                             : item.phy_tx_code;
            n.hold_count = '0;
            n.phase = cfg.hold_result ? PH_HOLD : PH_IDLE;
          end
        end
        // a send that just finished counts this same tick toward the hold
        if (n.phase == PH_HOLD) begin
          n.hold_count = inc16(n.hold_count);
          if (n.hold_count >= cfg.hold_timeout) begin
            n.phase = PH_IDLE;
          end
        end
      end
      ACT_CONFIRM: begin
        if (n.phase == PH_ASSESS && n.sub_phase == SUB_CCA) begin
          if (!item.channel_busy) begin
            go_tx = 1'b1;
          end else begin
            top = (cfg.max_backoff_slots == 8'd0) ? 8'd1 : cfg.max_backoff_slots;
            draw = (item.backoff_draw == 8'd0) ? 8'd1 : item.backoff_draw;
            n.backoff_left = (draw > top) ? top : draw;
            n.sub_phase = SUB_WAIT;
            if (n.attempts != 8'hFF) begin
              n.attempts = n.attempts + 8'd1;
            end
            // force the frame out after the attempt limit
            go_tx = (n.attempts >= cfg.max_attempts);
          end
          if (go_tx) begin
            n.sub_phase = SUB_TX;
            n.ack_count = '0;
            n.phase = PH_TX;
          end
        end
      end
      ACT_DATA: begin
        if (item.payload_length <= 16'(MAX_PAYLOAD)) begin
          n.data_handle = item.frame_handle;
          n.data_length = item.payload_length[7:0];
          if (n.phase != PH_IDLE) begin
            n.pending_data = 1'b1;
          end else begin
            go_data = 1'b1;
          end
        end
      end
      ACT_STOP: begin
        n.stop_life = (item.life_period > 8'(LIFE_MAX)) ? LIFE_MAX
                                                        : item.life_period[1:0];
        n.stop_net = item.network_wide ? cfg.broadcast_net_id : cfg.own_net_id;
        n.stop_handle = item.frame_handle;
        if (n.phase != PH_IDLE) begin
          n.pending_stop = 1'b1;
        end else begin
          go_stop = 1'b1;
        end
      end
      ACT_POLL: begin
        // a queued stop relay goes before a queued data send
        if (n.phase == PH_IDLE) begin
          if (n.pending_stop) begin
            n.pending_stop = 1'b0;
            go_stop = 1'b1;
          end else if (n.pending_data) begin
            n.pending_data = 1'b0;
            go_data = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (go_stop) begin
      n.attempts = '0;
      n.result_code = FAILURE_CODE;
      n.sub_phase = SUB_TX;
      n.ack_count = '0;
      n.phase = PH_TX;
    end
    if (go_data) begin
      n.attempts = '0;
      n.result_code = FAILURE_CODE;
      n.sub_phase = SUB_CCA;
      n.start_count = '0;
      n.phase = PH_ASSESS;
    end

    st_next = n;
  end

  // A transmit starts on entry to PH_TX: from idle it is a stop relay, from
  // assessment a data frame. An assessment request starts on entry to the CCA sub-phase.
  always_comb begin : outputs
    logic tx_start;
    logic cca_start;
    logic stop_start;

    tx_start = (st.phase != PH_TX) && (st_next.phase == PH_TX);
    cca_start = (st_next.phase == PH_ASSESS) && (st_next.sub_phase == SUB_CCA) &&
                !((st.phase == PH_ASSESS) && (st.sub_phase == SUB_CCA));
    stop_start = tx_start && (st.phase == PH_IDLE);

    result = '0;
    if (tx_start) begin
      result.command = CMD_TX;
      if (stop_start) begin
        result.tx_is_stop_relay = 1'b1;
        result.tx_handle = st_next.stop_handle;
        result.tx_net_id = st_next.stop_net;
        result.tx_life = st_next.stop_life;
      end else begin
        result.tx_handle = st_next.data_handle;
        result.tx_length = st_next.data_length;
      end
    end else if (cca_start) begin
      result.command = CMD_CCA;
    end
    result.request_error = (item.action == ACT_DATA) &&
                           (item.payload_length > 16'(MAX_PAYLOAD));
    result.send_phase = st_next.phase;
    result.last_result = st_next.result_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, sub_phase: SUB_TX, default: '0};
    end else if (fire) begin
      st <= st_next;
    end
  end

`include "csma_transmit_controller_assert.svh"

  `CSMA_ASSERT_NEXT(a_tx_enters_tx, clk, rst, fire && result.command == CMD_TX,
                    st.phase == PH_TX)
  `CSMA_ASSERT_NEXT(a_cca_in_assess, clk, rst, fire && result.command == CMD_CCA,
                    st.phase == PH_ASSESS && st.sub_phase == SUB_CCA)
  `CSMA_ASSERT_NEXT(a_hold_without_word, clk, rst, !fire,
                    $stable(st.phase) && $stable(st.pending_stop))
  `CSMA_ASSERT_NOW(a_error_keeps_phase, clk, rst, fire && result.request_error,
                   result.send_phase == st.phase)

endmodule

`default_nettype wire

/* rtl/csma_transmit_controller.sv */
// A request word passes from the input register through the send state machine into the result register.
// One word per cycle while the receiver takes results; the input and result registers decouple the two sides.
// Each word is a single state update in the send state machine between the two registers.
// Reset (rst, synchronous): send state idle, queues and counters clear, config to defaults.
// Depends on csma_pkg, csma_if, csma_cfg, csma_in_stage, csma_core and csma_out_stage.
`default_nettype none

module csma_transmit_controller (
  input  logic       clk,
  input  logic       rst,
  csma_req_if.sink   req,
  csma_rsp_if.source rsp,
  csma_cfg_if.sink   cfg
);
  import csma_pkg::*;

  cfg_t      cfg_regs;
  logic      s1_valid;
  logic      s1_ready;
  in_item_t  s1_data;
  logic      s2_ready;
  out_item_t core_result;

  csma_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  csma_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req.data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // advance the state only when the word moves into the result register
  assign s1_ready = s2_ready;

  csma_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_valid && s2_ready),
    .item   (s1_data),
    .cfg    (cfg_regs),
    .result (core_result)
  );

  csma_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_data   (core_result),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

endmodule

`default_nettype wire

/* tb/csma_transmit_controller_tb.sv */
// Self-checking bench for csma_transmit_controller: directed and random request words,
// a word-level predictor of the send state machine, and a field-by-field result check.
// Depends on csma_pkg and the channel interfaces in csma_if.
module csma_transmit_controller_tb;
  import csma_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_CAP = 40;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 4'hF;

  logic clk = 1'b0;
  logic rst;

  csma_req_if req_ch ();
  csma_rsp_if rsp_ch ();
  csma_cfg_if cfg_ch ();

  csma_transmit_controller dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t  request_words[$];
  out_item_t status_due[$];
  int        mismatches = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;

  // Shadow of the controller: registers and send state
  cfg_t        shadow = CFG_RESET;
  phase_t      st_phase = PH_IDLE;
  sub_phase_t  st_sub = SUB_TX;
  logic [15:0] start_cnt = '0;
  logic [15:0] ack_cnt = '0;
  logic [15:0] hold_cnt = '0;
  logic [7:0]  backoff = '0;
  logic [7:0]  tries = '0;
  logic [7:0]  result = '0;
  logic        stop_waiting = 1'b0;
  logic        data_waiting = 1'b0;
  logic [7:0]  stop_handle = '0;
  logic [7:0]  data_handle = '0;
  logic [7:0]  data_len = '0;
  logic [1:0]  stop_life = '0;
  logic [15:0] stop_net = '0;

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void wrap_up();
    if (shadow.hold_result) begin
      hold_cnt = '0;
      st_phase = PH_HOLD;
    end else begin
      st_phase = PH_IDLE;
    end
  endfunction

  function automatic void launch_stop(inout out_item_t o);
    tries = '0;
    result = FAILURE_CODE;
    st_sub = SUB_TX;
    o.command = CMD_TX;
    o.tx_is_stop_relay = 1'b1;
    o.tx_handle = stop_handle;
    o.tx_length = '0;
    o.tx_net_id = stop_net;
    o.tx_life = stop_life;
    ack_cnt = '0;
    st_phase = PH_TX;
  endfunction

  function automatic void launch_data(inout out_item_t o);
    tries = '0;
    result = FAILURE_CODE;
    st_sub = SUB_CCA;
    o.command = CMD_CCA;
    start_cnt = '0;
    st_phase = PH_ASSESS;
  endfunction

  // Advance the shadow by one request word and return the status word it produces.
  function automatic out_item_t next_status(in_item_t w);
    out_item_t o;
    logic [7:0] top;
    logic [7:0] draw;
    o = '0;
    case (w.action)
      ACT_TICK: begin
        if (st_phase == PH_ASSESS) begin
          start_cnt = sat16(start_cnt);
          if (start_cnt >= shadow.start_timeout) begin
            result = FAILURE_CODE;
            wrap_up();
          end else if (st_sub == SUB_WAIT) begin
            if (backoff != 8'd0) backoff = backoff - 8'd1;
            if (backoff == 8'd0) begin
              st_sub = SUB_CCA;
              o.command = CMD_CCA;
            end
          end
        end
        if (st_phase == PH_TX) begin
          ack_cnt = sat16(ack_cnt);
          if (ack_cnt >= shadow.ack_timeout) begin
            result = FAILURE_CODE;
            wrap_up();
          end else if (w.phy_tx_done) begin
            result = w.phy_tx_code;
            wrap_up();
          end
        end
        // a send finishing on this tick already counts it toward the hold
        if (st_phase == PH_HOLD) begin
          hold_cnt = sat16(hold_cnt);
          if (hold_cnt >= shadow.hold_timeout) st_phase = PH_IDLE;
        end
      end
      ACT_CONFIRM: begin
        if (st_phase == PH_ASSESS && st_sub == SUB_CCA) begin
          if (!w.channel_busy) begin
            st_sub = SUB_TX;
          end else begin
            top = (shadow.max_backoff_slots != 8'd0) ? shadow.max_backoff_slots : 8'd1;
            draw = w.backoff_draw;
            if (draw < 8'd1) draw = 8'd1;
            if (draw > top) draw = top;
            backoff = draw;
            st_sub = SUB_WAIT;
            if (tries != 8'hFF) tries = tries + 8'd1;
            if (tries >= shadow.max_attempts) st_sub = SUB_TX;
          end
          if (st_sub == SUB_TX) begin
            o.command = CMD_TX;
            o.tx_handle = data_handle;
            o.tx_length = data_len;
            ack_cnt = '0;
            st_phase = PH_TX;
          end
        end
      end
      ACT_DATA: begin
        if (w.payload_length > MAX_PAYLOAD) begin
          o.request_error = 1'b1;
        end else begin
          data_handle = w.frame_handle;
          data_len = w.payload_length[7:0];
          if (st_phase != PH_IDLE) data_waiting = 1'b1;
          else launch_data(o);
        end
      end
      ACT_STOP: begin
        stop_life = (w.life_period > 8'd3) ? LIFE_MAX : w.life_period[1:0];
        stop_net = w.network_wide ? shadow.broadcast_net_id : shadow.own_net_id;
        stop_handle = w.frame_handle;
        if (st_phase != PH_IDLE) stop_waiting = 1'b1;
        else launch_stop(o);
      end
      ACT_POLL: begin
        if (st_phase == PH_IDLE) begin
          if (stop_waiting) begin
            stop_waiting = 1'b0;
            launch_stop(o);
          end else if (data_waiting) begin
            data_waiting = 1'b0;
            launch_data(o);
          end
        end
      end
      default: ;
    endcase
    o.send_phase = st_phase;
    o.last_result = result;
    return o;
  endfunction

  // Random content in every field; the caller picks the action.
  function automatic in_item_t make_word(logic [2:0] act);
    in_item_t w;
    w.action = act;
    w.channel_busy = 1'($urandom_range(0, 1));
    w.backoff_draw = 8'($urandom_range(0, 255));
    w.phy_tx_done = ($urandom_range(0, 99) < 30);
    w.phy_tx_code = 8'($urandom_range(0, 255));
    w.frame_handle = 8'($urandom_range(0, 255));
    w.payload_length = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, MAX_PAYLOAD))
                                                    : 16'($urandom_range(0, 65535));
    w.life_period = 8'($urandom_range(0, 255));
    w.network_wide = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic int queue_ticks(int count, logic done);
    in_item_t w;
    for (int k = 0; k < count; k++) begin
      w = make_word(ACT_TICK);
      w.phy_tx_done = done;
      request_words.push_back(w);
    end
    return count;
  endfunction

  // One complete send: an optional stop, a data request, busy confirms with backoff ticks,
  // a clear confirm, radio done, hold countdown and a poll for anything queued meanwhile.
  function automatic int queue_send_flow();
    in_item_t w;
    int n;
    int rounds;
    n = 0;
    if ($urandom_range(0, 99) < 20) begin
      request_words.push_back(make_word(ACT_STOP));
      n++;
    end
    w = make_word(ACT_DATA);
    w.payload_length = 16'($urandom_range(0, MAX_PAYLOAD));
    request_words.push_back(w);
    n++;
    rounds = $urandom_range(0, 3);
    for (int r = 0; r < rounds; r++) begin
      w = make_word(ACT_CONFIRM);
      w.channel_busy = 1'b1;
      if ($urandom_range(0, 99) < 80) w.backoff_draw = 8'($urandom_range(0, 4));
      request_words.push_back(w);
      n++;
      n += queue_ticks($urandom_range(0, 5), 1'b0);
    end
    w = make_word(ACT_CONFIRM);
    w.channel_busy = 1'b0;
    request_words.push_back(w);
    n++;
    n += queue_ticks($urandom_range(0, 3), 1'b0);
    n += queue_ticks(1, 1'b1);
    n += queue_ticks($urandom_range(0, 6), 1'b0);
    request_words.push_back(make_word(ACT_POLL));
    return n + 1;
  endfunction

  function automatic in_item_t noise_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return make_word(ACT_TICK);
    if (pick < 55) return make_word(ACT_CONFIRM);
    if (pick < 70) return make_word(ACT_DATA);
    if (pick < 82) return make_word(ACT_STOP);
    if (pick < 95) return make_word(ACT_POLL);
    return make_word(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
  endfunction

  task automatic queue_random(int words);
    int added;
    added = 0;
    while (added < words) begin
      if ($urandom_range(0, 99) < 75) begin
        added += queue_send_flow();
      end else begin
        request_words.push_back(noise_word());
        added++;
      end
    end
  endtask

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: got %0h, expected %0h", field, got, want);
    mismatches++;
  endtask

  task automatic check_status(out_item_t got, out_item_t want);
    if (got.command !== want.command)
      report_mismatch("command", 16'(got.command), 16'(want.command));
    if (got.tx_is_stop_relay !== want.tx_is_stop_relay)
      report_mismatch("tx_is_stop_relay", 16'(got.tx_is_stop_relay), 16'(want.tx_is_stop_relay));
    if (got.tx_handle !== want.tx_handle)
      report_mismatch("tx_handle", 16'(got.tx_handle), 16'(want.tx_handle));
    if (got.tx_length !== want.tx_length)
      report_mismatch("tx_length", 16'(got.tx_length), 16'(want.tx_length));
    if (got.tx_net_id !== want.tx_net_id)
      report_mismatch("tx_net_id", got.tx_net_id, want.tx_net_id);
    if (got.tx_life !== want.tx_life)
      report_mismatch("tx_life", 16'(got.tx_life), 16'(want.tx_life));
    if (got.send_phase !== want.send_phase)
      report_mismatch("send_phase", 16'(got.send_phase), 16'(want.send_phase));
    if (got.last_result !== want.last_result)
      report_mismatch("last_result", 16'(got.last_result), 16'(want.last_result));
    if (got.request_error !== want.request_error)
      report_mismatch("request_error", 16'(got.request_error), 16'(want.request_error));
  endtask

  // Leaves valid high so back-to-back writes never drop it in between.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_MAX_BACKOFF_SLOTS: shadow.max_backoff_slots = value[7:0];
      CFG_START_TIMEOUT:     shadow.start_timeout = value;
      CFG_ACK_TIMEOUT:       shadow.ack_timeout = value;
      CFG_HOLD_TIMEOUT:      shadow.hold_timeout = value;
      CFG_MAX_ATTEMPTS:      shadow.max_attempts = value[7:0];
      CFG_OWN_NET_ID:        shadow.own_net_id = value;
      CFG_BROADCAST_NET_ID:  shadow.broadcast_net_id = value;
      CFG_HOLD_RESULT:       shadow.hold_result = value[0];
      default: ;
    endcase
  endtask

  task automatic load_setting(cfg_t s);
    write_reg(CFG_MAX_BACKOFF_SLOTS, 16'(s.max_backoff_slots));
    write_reg(CFG_START_TIMEOUT, s.start_timeout);
    write_reg(CFG_ACK_TIMEOUT, s.ack_timeout);
    write_reg(CFG_HOLD_TIMEOUT, s.hold_timeout);
    write_reg(CFG_MAX_ATTEMPTS, 16'(s.max_attempts));
    write_reg(CFG_OWN_NET_ID, s.own_net_id);
    write_reg(CFG_BROADCAST_NET_ID, s.broadcast_net_id);
    write_reg(CFG_HOLD_RESULT, 16'(s.hold_result));
    cfg_ch.valid <= 1'b0;
  endtask

  // Always waits on the clock before checking, so a following config write never
  // lowers and raises valid in the same step.
  task automatic wait_drained();
    do @(posedge clk);
    while (request_words.size() != 0 || req_ch.valid || status_due.size() != 0);
  endtask

  // Request driver: predict each accepted word, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        status_due.push_back(next_status(req_ch.data));
      if (req_ch.valid && !req_ch.ready) begin
        // hold the word until it is taken
      end else if (request_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= request_words.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_due.size() == 0) begin
          report_mismatch("unexpected word", 16'(rsp_ch.data.send_phase), 16'd0);
        end else begin
          want = status_due.pop_front();
          check_status(rsp_ch.data, want);
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t w;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Short timeouts and few attempts so the directed words walk every phase.
    send_gap_pct = 8;
    recv_stall_pct = 51;
    write_reg(CFG_SPARE_INDEX, 16'($urandom_range(0, 65535)));
    load_setting('{max_backoff_slots: 8'd3, start_timeout: 16'd40, ack_timeout: 16'd12,
                   hold_timeout: 16'd5, max_attempts: 8'd2,
                   own_net_id: 16'($urandom_range(0, 65535)),
                   broadcast_net_id: 16'($urandom_range(0, 65535)), hold_result: 1'b1});

    request_words.push_back(make_word(ACT_POLL));
    w = make_word(ACT_DATA);
    w.payload_length = 16'hFFFF;
    request_words.push_back(w);
    w = make_word(ACT_DATA);
    w.payload_length = 16'(MAX_PAYLOAD + 1);
    request_words.push_back(w);
    w = make_word(ACT_DATA);
    w.frame_handle = 8'hFF;
    w.payload_length = 16'(MAX_PAYLOAD);
    request_words.push_back(w);
    // busy with a zero draw clamps to one slot
    w = make_word(ACT_CONFIRM);
    w.channel_busy = 1'b1;
    w.backoff_draw = 8'h00;
    request_words.push_back(w);
    // confirm during backoff is dropped
    request_words.push_back(make_word(ACT_CONFIRM));
    void'(queue_ticks(1, 1'b0));
    // oversized draw clamps, and the attempt limit forces the frame out
    w = make_word(ACT_CONFIRM);
    w.channel_busy = 1'b1;
    w.backoff_draw = 8'hFF;
    request_words.push_back(w);
    w = make_word(ACT_STOP);
    w.frame_handle = 8'hA5;
    w.life_period = 8'hFF;
    w.network_wide = 1'b1;
    request_words.push_back(w);
    // queued data request overwrites the data registers
    w = make_word(ACT_DATA);
    w.frame_handle = 8'h00;
    w.payload_length = 16'd0;
    request_words.push_back(w);
    request_words.push_back(make_word(ACT_SPARE_LO));
    request_words.push_back(make_word(ACT_SPARE_HI));
    w = make_word(ACT_TICK);
    w.phy_tx_done = 1'b1;
    w.phy_tx_code = 8'hFF;
    request_words.push_back(w);
    request_words.push_back(make_word(ACT_POLL));
    void'(queue_ticks(4, 1'b0));
    // stop relay goes out before the queued data send
    request_words.push_back(make_word(ACT_POLL));
    w = make_word(ACT_TICK);
    w.phy_tx_done = 1'b1;
    w.phy_tx_code = 8'h00;
    request_words.push_back(w);
    void'(queue_ticks(4, 1'b0));
    request_words.push_back(make_word(ACT_POLL));
    w = make_word(ACT_CONFIRM);
    w.channel_busy = 1'b0;
    request_words.push_back(w);
    w = make_word(ACT_STOP);
    w.frame_handle = 8'h3C;
    w.life_period = 8'd2;
    w.network_wide = 1'b0;
    request_words.push_back(w);
    queue_random(200);
    wait_drained();

    // Largest values; the sender pauses midway until every result is back.
    load_setting('{max_backoff_slots: 8'hFF, start_timeout: 16'hFFFF, ack_timeout: 16'hFFFF,
                   hold_timeout: 16'hFFFF, max_attempts: 8'hFF, own_net_id: 16'h0000,
                   broadcast_net_id: 16'hFFFF, hold_result: 1'b0});
    queue_random(75);
    wait_drained();
    queue_random(75);
    wait_drained();

    send_gap_pct = 51;
    recv_stall_pct = 8;
    load_setting('{max_backoff_slots: 8'd1, start_timeout: 16'd1, ack_timeout: 16'd1,
                   hold_timeout: 16'd1, max_attempts: 8'd1, own_net_id: 16'hFFFF,
                   broadcast_net_id: 16'h0000, hold_result: 1'b1});
    queue_random(150);
    wait_drained();

    // Zero backoff slots and zero attempts
    load_setting('{max_backoff_slots: 8'd0, start_timeout: 16'd20, ack_timeout: 16'd8,
                   hold_timeout: 16'd3, max_attempts: 8'd0,
                   own_net_id: 16'($urandom_range(0, 65535)),
                   broadcast_net_id: 16'($urandom_range(0, 65535)), hold_result: 1'b0});
    queue_random(150);
    wait_drained();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    load_setting('{max_backoff_slots: 8'd8, start_timeout: 16'd30, ack_timeout: 16'd15,
                   hold_timeout: 16'd4, max_attempts: 8'd4,
                   own_net_id: 16'($urandom_range(0, 65535)),
                   broadcast_net_id: 16'($urandom_range(0, 65535)), hold_result: 1'b1});
    queue_random(200);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
